// ===== sv/cpse_pkg.sv =====
// cpse_pkg: shared types, codes and constants of the postfix stack evaluator
// used by the top level, the arithmetic unit and the port checker
`default_nettype none
package cpse_pkg;

   // action codes
   localparam logic [1:0] ACT_PUSH = 2'd0;
   localparam logic [1:0] ACT_OP   = 2'd1;
   localparam logic [1:0] ACT_END  = 2'd2;

   // operator codes
   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_MOD = 3'd4;
   localparam logic [2:0] OP_LCM = 3'd5;

   // status codes
   localparam logic [2:0] ST_OK   = 3'd0;
   localparam logic [2:0] ST_FEW  = 3'd1;
   localparam logic [2:0] ST_LEFT = 3'd2;
   localparam logic [2:0] ST_DIVZ = 3'd3;
   localparam logic [2:0] ST_OVF  = 3'd4;
   localparam logic [2:0] ST_LCMZ = 3'd5;
   localparam logic [2:0] ST_FULL = 3'd6;

   localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAXPOS = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] ALL1   = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [63:0] operand_value;
      logic [2:0]         operator_code;
   } req_type;

   typedef struct packed {
      logic signed [63:0] result_value;
      logic [2:0]         status;
      logic               final_flag;
   } rsp_type;

   // control of the arithmetic unit
   typedef struct packed {
      logic        start;
      logic [2:0]  op;
   } alu_ctl_type;

   typedef struct packed {
      logic        done;
      logic [2:0]  status;
   } alu_sts_type;

   typedef enum logic [2:0] {
      S_IDLE, S_RD_B, S_RD_A, S_START, S_CALC, S_RD_E, S_END, S_DONE
   } state_type;

   typedef enum logic [3:0] {
      A_IDLE, A_ADD, A_MUL, A_DIV, A_DIVFIN, A_MULFIN, A_GINIT, A_GLOOP, A_GSHIFT,
      A_DONE
   } alu_state_type;

endpackage
`default_nettype wire

// ===== sv/cpse_alu.sv =====
// cpse_alu: serial arithmetic unit, add/sub one bit a cycle, shift-add multiply,
// restoring divide and binary gcd for lcm; depends on cpse_pkg
`default_nettype none
module cpse_alu (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cpse_pkg::alu_ctl_type ctl,
   input  wire logic [63:0]        a,
   input  wire logic [63:0]        b,
   output cpse_pkg::alu_sts_type   sts,
   output logic [63:0]             result
);
   import cpse_pkg::*;

   alu_state_type state_ff, state_in;
   logic [63:0] x_ff, x_in, y_ff, y_in, acc_ff, acc_in, b_ff, b_in;
   logic [63:0] ma_ff, ma_in, mb_ff, mb_in, res_ff, res_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [5:0]  k_ff, k_in;
   logic [2:0]  op_ff, op_in, st_ff, st_in;
   logic        c_ff, c_in, ovf_ff, ovf_in, na_ff, na_in, nb_ff, nb_in;

   logic [63:0] ma, mb;
   logic        sbit, cout;
   logic [64:0] msum, dsub;
   logic [63:0] rsh, lim;

   assign ma = a[63] ? (64'd0 - a) : a;
   assign mb = b[63] ? (64'd0 - b) : b;

   // serial adder bit, multiply step, divide step
   assign sbit = x_ff[0] ^ y_ff[0] ^ c_ff;
   assign cout = (x_ff[0] & y_ff[0]) | (c_ff & (x_ff[0] ^ y_ff[0]));
   assign msum = {acc_ff, 1'b0} + {1'b0, (y_ff[63] ? x_ff : 64'd0)};
   assign rsh  = {acc_ff[62:0], x_ff[63]};
   assign dsub = {1'b0, rsh} - {1'b0, y_ff};
   assign lim  = (na_ff != nb_ff) ? SIGN64 : MAXPOS;

   // next state and datapath
   always_comb begin
      state_in = state_ff;
      x_in = x_ff; y_in = y_ff; acc_in = acc_ff; b_in = b_ff;
      ma_in = ma_ff; mb_in = mb_ff; res_in = res_ff;
      cnt_in = cnt_ff; k_in = k_ff; op_in = op_ff; st_in = st_ff;
      c_in = c_ff; ovf_in = ovf_ff; na_in = na_ff; nb_in = nb_ff;
      unique case (state_ff)
         A_IDLE: begin
            if (ctl.start) begin
               op_in = ctl.op; b_in = b; na_in = a[63]; nb_in = b[63];
               ma_in = ma; mb_in = mb; acc_in = 64'd0; cnt_in = 7'd0;
               ovf_in = 1'b0; k_in = 6'd0; st_in = ST_OK; res_in = 64'd0;
               state_in = A_DONE;
               priority case (ctl.op)
                  OP_ADD: begin
                     x_in = a; y_in = b; c_in = 1'b0; state_in = A_ADD;
                  end
                  OP_SUB: begin
                     x_in = a; y_in = ~b; c_in = 1'b1; state_in = A_ADD;
                  end
                  OP_MUL: begin
                     if (ma != 64'd0 && mb != 64'd0) begin
                        x_in = ma; y_in = mb; state_in = A_MUL;
                     end
                  end
                  OP_DIV: begin
                     if (b == 64'd0) st_in = ST_DIVZ;
                     else if (a == SIGN64 && b == ALL1) st_in = ST_OVF;
                     else begin
                        x_in = ma; y_in = mb; state_in = A_DIV;
                     end
                  end
                  OP_MOD: begin
                     if (b == 64'd0) st_in = ST_DIVZ;
                     else if (b != ALL1) begin
                        x_in = ma; y_in = mb; state_in = A_DIV;
                     end
                  end
                  default: begin
                     if (a == 64'd0 || b == 64'd0) st_in = ST_LCMZ;
                     else begin
                        x_in = ma; y_in = mb; state_in = A_GINIT;
                     end
                  end
               endcase
            end
         end
         A_ADD: begin
            acc_in = {sbit, acc_ff[63:1]};
            x_in = {1'b0, x_ff[63:1]};
            y_in = {1'b0, y_ff[63:1]};
            c_in = cout;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) begin
               res_in = {sbit, acc_ff[63:1]};
               if (op_ff == OP_ADD) begin
                  if (na_ff == nb_ff && sbit != na_ff) st_in = ST_OVF;
               end else begin
                  if (na_ff != nb_ff && sbit != na_ff) st_in = ST_OVF;
               end
               state_in = A_DONE;
            end
         end
         A_MUL: begin
            acc_in = msum[63:0];
            ovf_in = ovf_ff | acc_ff[63] | msum[64];
            y_in = {y_ff[62:0], 1'b0};
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) state_in = A_MULFIN;
         end
         A_MULFIN: begin
            state_in = A_DONE;
            if (op_ff == OP_LCM) begin
               if (ovf_ff || acc_ff > MAXPOS) st_in = ST_OVF;
               else res_in = acc_ff;
            end else begin
               if (ovf_ff || acc_ff > lim) st_in = ST_OVF;
               else res_in = (na_ff != nb_ff) ? (64'd0 - acc_ff) : acc_ff;
            end
         end
         A_DIV: begin
            if (!dsub[64]) begin
               acc_in = dsub[63:0];
               x_in = {x_ff[62:0], 1'b1};
            end else begin
               acc_in = rsh;
               x_in = {x_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) state_in = A_DIVFIN;
         end
         A_DIVFIN: begin
            priority case (op_ff)
               OP_DIV: begin
                  res_in = (na_ff != nb_ff) ? (64'd0 - x_ff) : x_ff;
                  state_in = A_DONE;
               end
               OP_MOD: begin
                  // floored sign: result follows the divisor
                  if (acc_ff == 64'd0) res_in = 64'd0;
                  else if (na_ff == nb_ff) res_in = na_ff ? (64'd0 - acc_ff) : acc_ff;
                  else res_in = na_ff ? (b_ff - acc_ff) : (acc_ff + b_ff);
                  state_in = A_DONE;
               end
               default: begin
                  // lcm: quotient times second magnitude
                  y_in = mb_ff; acc_in = 64'd0; ovf_in = 1'b0; cnt_in = 7'd0;
                  state_in = A_MUL;
               end
            endcase
         end
         A_GINIT: begin
            if (!x_ff[0] && !y_ff[0]) begin
               x_in = {1'b0, x_ff[63:1]};
               y_in = {1'b0, y_ff[63:1]};
               k_in = k_ff + 6'd1;
            end else begin
               state_in = A_GLOOP;
            end
         end
         A_GLOOP: begin
            priority if (!x_ff[0]) x_in = {1'b0, x_ff[63:1]};
            else if (y_ff == 64'd0) state_in = A_GSHIFT;
            else if (!y_ff[0]) y_in = {1'b0, y_ff[63:1]};
            else if (x_ff > y_ff) begin
               x_in = y_ff;
               y_in = x_ff - y_ff;
            end else y_in = y_ff - x_ff;
         end
         A_GSHIFT: begin
            if (k_ff == 6'd0) begin
               // divide first magnitude by the gcd
               y_in = x_ff; x_in = ma_ff; acc_in = 64'd0; cnt_in = 7'd0;
               state_in = A_DIV;
            end else begin
               x_in = {x_ff[62:0], 1'b0};
               k_in = k_ff - 6'd1;
            end
         end
         default: state_in = A_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      sts.done   = (state_ff == A_DONE);
      sts.status = st_ff;
      result     = res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff <= x_in; y_ff <= y_in; acc_ff <= acc_in; b_ff <= b_in;
      ma_ff <= ma_in; mb_ff <= mb_in; res_ff <= res_in;
      cnt_ff <= cnt_in; k_ff <= k_in; op_ff <= op_in; st_ff <= st_in;
      c_ff <= c_in; ovf_ff <= ovf_in; na_ff <= na_in; nb_ff <= nb_in;
   end
endmodule
`default_nettype wire

// ===== sv/checked_postfix_stack_evaluator_unit.sv =====
// push, ignored and error-at-entry requests go straight to S_DONE; end of
// expression reads the stack via S_RD_E, S_END; add/sub and mul/div/mod are paced
// by the 64-step serial unit, lcm by the binary gcd loop plus divide and multiply
// one request at a time; a new request is taken while the last result waits
// synchronous active-high reset empties the stack and drops any pending result
`default_nettype none
module checked_postfix_stack_evaluator_unit #(
   parameter int STACK_DEPTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cpse_pkg::req_type req_payload,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output cpse_pkg::rsp_type      rsp_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready
);
   import cpse_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [63:0] mem [STACK_DEPTH];
   logic [63:0] rdata_ff;
   state_type   state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in, cnt_m1, cnt_m2;
   logic [63:0] b_ff, b_in;
   logic [2:0]  op_ff, op_in;
   rsp_type     pend_ff, pend_in, rsp_ff, rsp_in;
   logic        rspv_ff, rspv_in;
   logic        we, accept, out_free;
   logic [AW-1:0] waddr, raddr;
   logic [63:0] wdata;
   alu_ctl_type actl;
   alu_sts_type asts;
   logic [63:0] ares;

   assign accept   = req_valid && req_ready;
   assign out_free = !rspv_ff || rsp_ready;
   assign cnt_m1   = cnt_ff - CW'(1);
   assign cnt_m2   = cnt_ff - CW'(2);
   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rspv_ff;
   assign rsp_payload = rsp_ff;

   cpse_alu u_alu (
      .clock (clock), .reset (reset), .ctl (actl),
      .a (rdata_ff), .b (b_ff), .sts (asts), .result (ares)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_payload.action == ACT_OP && req_payload.operator_code <= OP_LCM
                   && cnt_ff >= CW'(2)) state_in = S_RD_B;
               else if (req_payload.action == ACT_END && cnt_ff == CW'(1))
                  state_in = S_RD_E;
               else state_in = S_DONE;
            end
         end
         S_RD_B:  state_in = S_RD_A;
         S_RD_A:  state_in = S_START;
         S_START: state_in = S_CALC;
         S_CALC:  if (asts.done) state_in = S_DONE;
         S_RD_E:  state_in = S_END;
         S_END:   state_in = S_DONE;
         S_DONE:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // stack control and result staging
   always_comb begin
      cnt_in = cnt_ff; pend_in = pend_ff; b_in = b_ff; op_in = op_ff;
      we = 1'b0; waddr = cnt_ff[AW-1:0]; wdata = req_payload.operand_value;
      raddr = '0; actl.start = 1'b0; actl.op = op_ff;
      rsp_in = rsp_ff; rspv_in = rspv_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = req_payload.operator_code;
               pend_in = '{64'sd0, ST_OK, 1'b0};
               unique case (req_payload.action)
                  ACT_PUSH: begin
                     if (cnt_ff >= CW'(STACK_DEPTH)) begin
                        pend_in.status = ST_FULL;
                        cnt_in = '0;
                     end else begin
                        we = 1'b1;
                        cnt_in = cnt_ff + CW'(1);
                        pend_in.result_value = req_payload.operand_value;
                     end
                  end
                  ACT_OP: begin
                     if (req_payload.operator_code <= OP_LCM && cnt_ff < CW'(2)) begin
                        pend_in.status = ST_FEW;
                        cnt_in = '0;
                     end
                  end
                  ACT_END: begin
                     pend_in.final_flag = 1'b1;
                     if (cnt_ff != CW'(1)) begin
                        pend_in.status = ST_LEFT;
                        cnt_in = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RD_B: raddr = cnt_m1[AW-1:0];
         S_RD_A: begin
            b_in = rdata_ff;
            raddr = cnt_m2[AW-1:0];
         end
         S_START: actl.start = 1'b1;
         S_CALC: begin
            if (asts.done) begin
               if (asts.status == ST_OK) begin
                  we = 1'b1; waddr = cnt_m2[AW-1:0]; wdata = ares;
                  cnt_in = cnt_m1;
                  pend_in = '{ares, ST_OK, 1'b0};
               end else begin
                  cnt_in = '0;
                  pend_in = '{64'sd0, asts.status, 1'b0};
               end
            end
         end
         S_RD_E: raddr = '0;
         S_END: begin
            pend_in = '{rdata_ff, ST_OK, 1'b1};
            cnt_in = '0;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_in = pend_ff;
               rspv_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // stack memory
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         rspv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rspv_ff  <= rspv_in;
      end
      b_ff <= b_in; op_ff <= op_in; pend_ff <= pend_in; rsp_ff <= rsp_in;
   end
endmodule
`default_nettype wire

// ===== sv/cpse_checker.sv =====
// cpse_checker: port-level assertions for the postfix stack evaluator
// depends on cpse_pkg; bound to checked_postfix_stack_evaluator_unit
`default_nettype none
module cpse_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire cpse_pkg::req_type req_payload,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire cpse_pkg::rsp_type rsp_payload,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready
);
   import cpse_pkg::*;

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // errors carry a zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ST_OK |-> rsp_payload.result_value == 64'sd0)
      else $error("error result with non-zero value");

   // one request at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // nothing pending straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind checked_postfix_stack_evaluator_unit cpse_checker u_cpse_checker (
   .clock (clock), .reset (reset), .req_payload (req_payload), .req_valid (req_valid),
   .req_ready (req_ready), .rsp_payload (rsp_payload), .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready)
);
`default_nettype wire

// ===== tb/sv/checked_postfix_stack_evaluator_unit_tb.sv =====
// checked_postfix_stack_evaluator_unit_tb: random and directed test of the postfix evaluator
// depends on cpse_pkg and checked_postfix_stack_evaluator_unit; own predictor of stack and ops
`timescale 1ns / 1ps
module checked_postfix_stack_evaluator_unit_tb;
   import cpse_pkg::*;

   localparam int DEPTH = 16;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   req_type req_payload = '0;
   logic    req_valid = 1'b0;
   logic    req_ready;
   rsp_type rsp_payload;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;

   checked_postfix_stack_evaluator_unit #(.STACK_DEPTH(DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_payload(req_payload), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_payload(rsp_payload), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready)
   );

   always #1 clock = ~clock;

   // predictor state
   logic [63:0] model_stack [DEPTH];
   int          model_depth = 0;
   rsp_type     expected_results [$];
   int          mismatch_count = 0;
   bit          idle_enable = 1'b1;
   int          stall_left = 0;

   function automatic logic [63:0] mag(logic [63:0] x);
      return x[63] ? -x : x;
   endfunction

   // checked arithmetic; returns status, result through r
   function automatic logic [2:0] calc(logic [2:0] op, logic [63:0] a, logic [63:0] b,
                                       output logic [63:0] r);
      logic [127:0] prod;
      logic [63:0]  ma, mb, x, y, t, q, lim;
      logic signed [63:0] sa, sb, m;
      r = '0;
      sa = a;
      sb = b;
      case (op)
         OP_ADD: begin
            r = a + b;
            if (a[63] == b[63] && r[63] != a[63]) return ST_OVF;
         end
         OP_SUB: begin
            r = a - b;
            if (a[63] != b[63] && r[63] != a[63]) return ST_OVF;
         end
         OP_MUL: begin
            ma = mag(a);
            mb = mag(b);
            if (ma == 0 || mb == 0) return ST_OK;
            prod = ma * mb;
            lim = (a[63] != b[63]) ? SIGN64 : MAXPOS;
            if (prod[127:64] != 0 || prod[63:0] > lim) return ST_OVF;
            r = (a[63] != b[63]) ? -prod[63:0] : prod[63:0];
         end
         OP_DIV: begin
            if (b == 0) return ST_DIVZ;
            if (a == SIGN64 && b == ALL1) return ST_OVF;
            r = sa / sb;
         end
         OP_MOD: begin
            if (b == 0) return ST_DIVZ;
            if (b == ALL1) return ST_OK;
            m = sa % sb;
            if (m != 0 && ((m < 0) != (sb < 0))) m = m + sb;
            r = m;
         end
         OP_LCM: begin
            if (a == 0 || b == 0) return ST_LCMZ;
            ma = mag(a);
            mb = mag(b);
            x = ma;
            y = mb;
            while (y != 0) begin
               t = x % y;
               x = y;
               y = t;
            end
            q = ma / x;
            if (q > MAXPOS / mb) return ST_OVF;
            r = q * mb;
         end
         default: ;
      endcase
      return ST_OK;
   endfunction

   // expected result of one request, updating the model stack
   function automatic rsp_type predict_token(req_type rq);
      rsp_type     e;
      logic [63:0] r;
      logic [2:0]  st;
      e = '0;
      case (rq.action)
         ACT_PUSH: begin
            if (model_depth >= DEPTH) begin
               e.status = ST_FULL;
               model_depth = 0;
            end else begin
               model_stack[model_depth] = rq.operand_value;
               model_depth++;
               e.result_value = rq.operand_value;
            end
         end
         ACT_OP: begin
            if (rq.operator_code <= OP_LCM) begin
               if (model_depth < 2) begin
                  e.status = ST_FEW;
                  model_depth = 0;
               end else begin
                  st = calc(rq.operator_code, model_stack[model_depth-2],
                            model_stack[model_depth-1], r);
                  e.status = st;
                  if (st == ST_OK) begin
                     model_depth--;
                     model_stack[model_depth-1] = r;
                     e.result_value = r;
                  end else begin
                     model_depth = 0;
                  end
               end
            end
         end
         ACT_END: begin
            e.final_flag = 1'b1;
            if (model_depth == 1) e.result_value = model_stack[0];
            else e.status = ST_LEFT;
            model_depth = 0;
         end
         default: ;
      endcase
      return e;
   endfunction

   // random idle burst
   task automatic idle_gap();
      if (idle_enable && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 19)) @(posedge clock);
   endtask

   // send one request and record its expected result
   task automatic send_request(logic [1:0] act, logic [63:0] val, logic [2:0] op);
      req_type rq;
      rq.action = act;
      rq.operand_value = val;
      rq.operator_code = op;
      idle_gap();
      req_payload <= rq;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_results.push_back(predict_token(rq));
      req_valid <= 1'b0;
      // the block is busy for at least this cycle after taking a request
      @(posedge clock);
   endtask

   task automatic push_value(logic [63:0] v);
      send_request(ACT_PUSH, v, 3'($urandom_range(0, 7)));
   endtask

   task automatic apply_op(logic [2:0] op);
      send_request(ACT_OP, {$urandom, $urandom}, op);
   endtask

   task automatic end_expr();
      send_request(ACT_END, {$urandom, $urandom}, 3'($urandom_range(0, 7)));
   endtask

   task automatic binary_expr(logic [63:0] a, logic [63:0] b, logic [2:0] op);
      push_value(a);
      push_value(b);
      apply_op(op);
      end_expr();
   endtask

   // result stall in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else if (!idle_enable) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 19) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // result checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result %h", rsp_payload);
         end else begin
            e = expected_results.pop_front();
            if (rsp_payload.result_value !== e.result_value ||
                rsp_payload.status !== e.status ||
                rsp_payload.final_flag !== e.final_flag) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected value %h status %0d final %0d, got %h %0d %0d",
                           e.result_value, e.status, e.final_flag,
                           rsp_payload.result_value, rsp_payload.status,
                           rsp_payload.final_flag);
            end
         end
      end
   end

   task automatic wait_drained();
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 7))
         0: return SIGN64;
         1: return MAXPOS;
         2: return ALL1;
         3: return 64'd0;
         4: return {$urandom, $urandom};
         5: return {{32{1'b0}}, $urandom} >> $urandom_range(0, 31);
         default: return 64'($signed(($urandom_range(0, 2000))) - 1000);
      endcase
   endfunction

   // edge cases of every operator
   task automatic test_operator_edges();
      binary_expr(MAXPOS, 64'd1, OP_ADD);
      binary_expr(SIGN64, 64'd1, OP_SUB);
      binary_expr(SIGN64, ALL1, OP_MUL);
      binary_expr(-64'd7, 64'd3, OP_MUL);
      binary_expr(SIGN64, ALL1, OP_DIV);
      binary_expr(-64'd7, 64'd2, OP_DIV);
      binary_expr(64'd5, 64'd0, OP_DIV);
      binary_expr(SIGN64, ALL1, OP_MOD);
      binary_expr(-64'd7, 64'd3, OP_MOD);
      binary_expr(64'd7, -64'd3, OP_MOD);
      binary_expr(64'd7, 64'd0, OP_MOD);
      binary_expr(-64'd12, 64'd18, OP_LCM);
      binary_expr(64'd0, 64'd4, OP_LCM);
      binary_expr(MAXPOS, 64'd2, OP_LCM);
   endtask

   // structural errors and ignored requests
   task automatic test_stack_errors();
      apply_op(OP_ADD);
      end_expr();
      push_value(64'd3);
      push_value(64'd4);
      end_expr();
      push_value(64'd1);
      apply_op(3'd6);
      apply_op(3'd7);
      send_request(2'd3, ALL1, 3'd7);
      end_expr();
      for (int i = 0; i <= DEPTH; i++) push_value(64'(i));
      end_expr();
      wait_drained();
   endtask

   // random expressions, mostly well formed
   task automatic test_random_expressions(int count);
      int sent;
      int depth;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) == 0) begin
            send_request(2'($urandom_range(0, 3)), pick_value(),
                         3'($urandom_range(0, 7)));
            sent++;
         end else begin
            depth = 0;
            repeat ($urandom_range(1, 6)) begin
               if (depth < 2 || ($urandom_range(0, 1) && depth < DEPTH)) begin
                  push_value(pick_value());
                  depth++;
               end else begin
                  apply_op(3'($urandom_range(0, 5)));
                  depth--;
               end
               sent++;
            end
            while (depth > 1 && $urandom_range(0, 5) != 0) begin
               apply_op(3'($urandom_range(0, 5)));
               depth--;
               sent++;
            end
            end_expr();
            sent++;
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_operator_edges();
      test_stack_errors();
      test_random_expressions(310);
      idle_enable = 1'b0;
      test_random_expressions(60);
      wait_drained();
      repeat (400) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
sv/cpse_pkg.sv
sv/cpse_alu.sv
sv/checked_postfix_stack_evaluator_unit.sv
sv/cpse_checker.sv
tb/sv/checked_postfix_stack_evaluator_unit_tb.sv
